@@ hw/rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BAD     = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
	localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
	localparam logic [1:0] REG_NODE_ADDRESS  = 2'd2;

	// Register reset values
	localparam logic [7:0] RST_FIRST_HEADER  = 8'h55;
	localparam logic [7:0] RST_SECOND_HEADER = 8'hAA;
	localparam logic [7:0] RST_NODE_ADDRESS  = 8'h15;

	// Register set
	typedef struct packed {
		logic [7:0] first_header;
		logic [7:0] second_header;
		logic [7:0] node_address;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_length;
	} res_t;

endpackage

@@ hw/rtl/sfd_cfg.sv @@
// ----------------------------------------------------------------------------
// sfd_cfg
// Configuration registers: header values and node address.
// ----------------------------------------------------------------------------
module sfd_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	output sfd_pkg::cfg_t       cfg
);

	sfd_pkg::cfg_t cfg_q;

	// Register writes; an unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_header  <= sfd_pkg::RST_FIRST_HEADER;
			cfg_q.second_header <= sfd_pkg::RST_SECOND_HEADER;
			cfg_q.node_address  <= sfd_pkg::RST_NODE_ADDRESS;
		end else if (cfg_we) begin
			case (cfg_index)
				sfd_pkg::REG_FIRST_HEADER:  cfg_q.first_header  <= cfg_wdata;
				sfd_pkg::REG_SECOND_HEADER: cfg_q.second_header <= cfg_wdata;
				sfd_pkg::REG_NODE_ADDRESS:  cfg_q.node_address  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/sfd_parser.sv @@
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state and per-word decode: header hunt, length capture, payload
// indexing, running sum and checksum compare.
// ----------------------------------------------------------------------------
module sfd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,       // word in the input stage is consumed
	input  logic [7:0]          rx_byte,
	input  sfd_pkg::cfg_t       cfg,
	output logic                res_valid,
	output sfd_pkg::res_t       res
);

	logic [7:0] win_q [3];
	logic       receiving_q;
	logic [7:0] len_q;
	logic [7:0] count_q;
	logic [7:0] sum_q;

	logic hdr_match;
	logic in_payload;

	assign hdr_match  = (win_q[0] == cfg.first_header) &&
	                    (win_q[1] == cfg.second_header) &&
	                    (win_q[2] == cfg.node_address);
	assign in_payload = count_q < len_q;

	// Result for the current word
	always_comb begin
		res_valid        = receiving_q;
		res.data_byte    = rx_byte;
		res.frame_length = len_q;
		if (in_payload) begin
			res.result_kind = sfd_pkg::KIND_PAYLOAD;
			res.byte_index  = count_q;
		end else begin
			res.result_kind = (sum_q == rx_byte) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
			res.byte_index  = 8'd0;
		end
	end

	// Frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0]    <= 8'd0;
			win_q[1]    <= 8'd0;
			win_q[2]    <= 8'd0;
			receiving_q <= 1'b0;
			len_q       <= 8'd0;
			count_q     <= 8'd0;
			sum_q       <= 8'd0;
		end else if (step) begin
			if (!receiving_q) begin
				if (hdr_match) begin
					// length word: window kept as is
					receiving_q <= 1'b1;
					len_q       <= rx_byte;
					count_q     <= 8'd0;
					sum_q       <= 8'd0;
				end else begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= rx_byte;
				end
			end else if (in_payload) begin
				sum_q   <= sum_q + rx_byte;
				count_q <= count_q + 8'd1;
			end else begin
				// checksum word: back to hunting
				win_q[0]    <= 8'd0;
				win_q[1]    <= 8'd0;
				win_q[2]    <= 8'd0;
				receiving_q <= 1'b0;
				len_q       <= 8'd0;
				count_q     <= 8'd0;
				sum_q       <= 8'd0;
			end
		end
	end

endmodule

@@ hw/rtl/serial_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Byte-stream frame parser: header/address hunt, length, indexed payload and
// an additive checksum check at frame end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata[7:0] rx_byte
//  m_axis    out        tdata data_byte/byte_index/frame_length, tuser result_kind
//  cfg       in         write enable, index, 8-bit data, no read-back
//
//  One word per cycle sustained while results are taken downstream; input
//  register then result register, with the frame decode between them.
//  Reset (arst_n low) restores the register defaults and starts hunting with
//  an empty header window.
//  A full result register not taken downstream holds the input stage; words
//  that give no result pass through the same stages.
// ----------------------------------------------------------------------------
module serial_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [7:0] data_byte, [15:8] byte_index, [23:16] frame_length
	output logic [1:0]  m_tuser,    // [1:0] result_kind
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	sfd_pkg::cfg_t cfg;
	sfd_pkg::res_t res;
	sfd_pkg::res_t res_s2;
	logic          res_valid;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          valid_s2;
	logic          out_free;
	logic          step;

	assign out_free = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign step     = valid_s1 && out_free;

	sfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.frame_length, res_s2.byte_index, res_s2.data_byte};
	assign m_tuser  = res_s2.result_kind;

	// Payload index always lies inside the frame length
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sfd_pkg::KIND_PAYLOAD) |-> m_tdata[15:8] < m_tdata[23:16])
		else $error("payload index beyond frame length");

	// Frame-end results carry index zero
	a_end_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sfd_pkg::KIND_GOOD || m_tuser == sfd_pkg::KIND_BAD)
		|-> m_tdata[15:8] == 8'd0)
		else $error("frame end with non-zero index");

	// Only defined result kinds are shown
	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == sfd_pkg::KIND_PAYLOAD || m_tuser == sfd_pkg::KIND_GOOD ||
		              m_tuser == sfd_pkg::KIND_BAD))
		else $error("undefined result kind");

	// An empty result register never holds off the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

@@ tb/sv/frame_checker.sv @@
// ----------------------------------------------------------------------------
// frame_checker
// Watches the input, result and configuration channels of the serial frame
// deframer. It keeps its own header window, frame counters and register set,
// works out the result word for every accepted input word, and compares each
// result word taken downstream against the oldest one still waiting.
// ----------------------------------------------------------------------------
module frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,    // [7:0] data_byte, [15:8] byte_index, [23:16] frame_length
	input  logic [1:0]  m_tuser,    // [1:0] result_kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	output int          n_fail,
	output int          n_pending,
	output int          n_payload,
	output int          n_good,
	output int          n_bad
);
	timeunit 1ns;
	timeprecision 1ps;

	// Own copy of the registers and the parser state
	sfd_pkg::cfg_t   regs;
	logic [7:0]      window [3];
	logic            in_frame;
	logic [7:0]      payload_len;
	logic [7:0]      frame_count;
	logic [7:0]      frame_sum;
	sfd_pkg::res_t   expected_words [$];
	int              fail_total;
	int              payload_total;
	int              good_total;
	int              bad_total;

	// Back to hunting with an empty window
	function automatic void drop_frame();
		window[0]   = 8'h00;
		window[1]   = 8'h00;
		window[2]   = 8'h00;
		in_frame    = 1'b0;
		payload_len = 8'h00;
		frame_count = 8'h00;
		frame_sum   = 8'h00;
	endfunction

	// Parse one received byte; returns 1 when it yields a result word
	function automatic bit deframe_byte(input logic [7:0] rx, output sfd_pkg::res_t word);
		word = '0;
		if (!in_frame) begin
			if (window[0] == regs.first_header && window[1] == regs.second_header &&
			    window[2] == regs.node_address) begin
				// header and address seen: this byte is the length
				in_frame    = 1'b1;
				payload_len = rx;
				frame_count = 8'h00;
				frame_sum   = 8'h00;
			end else begin
				window[0] = window[1];
				window[1] = window[2];
				window[2] = rx;
			end
			return 1'b0;
		end
		word.data_byte    = rx;
		word.frame_length = payload_len;
		if (frame_count < payload_len) begin
			word.result_kind = sfd_pkg::KIND_PAYLOAD;
			word.byte_index  = frame_count;
			frame_sum        = frame_sum + rx;
			frame_count      = frame_count + 8'd1;
			return 1'b1;
		end
		// checksum byte, also straight after the length of an empty frame
		word.result_kind = (frame_sum == rx) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
		word.byte_index  = 8'h00;
		drop_frame();
		return 1'b1;
	endfunction

	// One line per mismatch
	task automatic report_mismatch(input string what, input logic [7:0] got,
	                               input logic [7:0] want);
		$display("%0t ns: mismatch in %s: got %02h, expected %02h", $time, what, got, want);
		fail_total++;
	endtask

	// Compare results, follow register writes, predict from accepted bytes
	always @(posedge clk or negedge arst_n) begin : watch
		sfd_pkg::res_t want;
		sfd_pkg::res_t next_word;
		if (!arst_n) begin
			regs.first_header  = sfd_pkg::RST_FIRST_HEADER;
			regs.second_header = sfd_pkg::RST_SECOND_HEADER;
			regs.node_address  = sfd_pkg::RST_NODE_ADDRESS;
			drop_frame();
			expected_words.delete();
			fail_total    = 0;
			payload_total = 0;
			good_total    = 0;
			bad_total     = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing expected, data_byte", m_tdata[7:0], 8'h00);
				end else begin
					want = expected_words.pop_front();
					if (m_tuser !== want.result_kind)
						report_mismatch("result_kind", {6'd0, m_tuser}, {6'd0, want.result_kind});
					if (m_tdata[7:0] !== want.data_byte)
						report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
					if (m_tdata[15:8] !== want.byte_index)
						report_mismatch("byte_index", m_tdata[15:8], want.byte_index);
					if (m_tdata[23:16] !== want.frame_length)
						report_mismatch("frame_length", m_tdata[23:16], want.frame_length);
					case (want.result_kind)
						sfd_pkg::KIND_PAYLOAD: payload_total++;
						sfd_pkg::KIND_GOOD:    good_total++;
						default:               bad_total++;
					endcase
				end
			end
			// out-of-range index writes nothing
			if (cfg_we) begin
				case (cfg_index)
					sfd_pkg::REG_FIRST_HEADER:  regs.first_header  = cfg_wdata;
					sfd_pkg::REG_SECOND_HEADER: regs.second_header = cfg_wdata;
					sfd_pkg::REG_NODE_ADDRESS:  regs.node_address  = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (deframe_byte(s_tdata, next_word))
					expected_words.push_back(next_word);
			end
		end
		n_fail    <= fail_total;
		n_pending <= expected_words.size();
		n_payload <= payload_total;
		n_good    <= good_total;
		n_bad     <= bad_total;
	end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Byte-stream stimulus for the serial frame deframer: a short run of hand-made
// frames, then random frames and noise under several header settings, with
// random idling on both channels, a long result hold-off and a maximum-length
// frame. Checking is left to frame_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_UNUSED      = 2'd3;   // no register behind this index
	localparam int         HOLD_CYCLES     = 200;
	localparam int         WATCHDOG_LIMIT  = 2000;
	localparam int         SETTLE_CYCLES   = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [7:0]  cfg_wdata = 8'h00;

	int n_fail, n_pending, n_payload, n_good, n_bad;

	// Stimulus side copy of the header registers
	logic [7:0] hdr_first  = sfd_pkg::RST_FIRST_HEADER;
	logic [7:0] hdr_second = sfd_pkg::RST_SECOND_HEADER;
	logic [7:0] hdr_addr   = sfd_pkg::RST_NODE_ADDRESS;

	int bytes_sent    = 0;
	int settings_used = 1;
	bit calm          = 1'b0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	always #4 clk = ~clk;

	serial_frame_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	frame_checker frame_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.n_fail    (n_fail),
		.n_pending (n_pending),
		.n_payload (n_payload),
		.n_good    (n_good),
		.n_bad     (n_bad)
	);

	// Result side: random stalls, calm stretches, and the long hold-off
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 38);
		end
	end

	// Watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one word, wait for the edge that takes it, now and then idle after it
	task automatic send_byte(input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		bytes_sent++;
		if (!calm && $urandom_range(0, 99) < 31) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_header(input logic [7:0] len);
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(hdr_addr);
		send_byte(len);
	endtask

	// Random payload, checksum right or random
	task automatic send_frame(input logic [7:0] len, input bit right_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = 8'h00;
		send_header(len);
		repeat (len) begin
			b   = 8'($urandom_range(0, 255));
			sum = sum + b;
			send_byte(b);
		end
		if (right_sum)
			send_byte(sum);
		else
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// Random bytes, now and then a header with the wrong address
	task automatic send_noise(input int count);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0) begin
				send_byte(hdr_first);
				send_byte(hdr_second);
				send_byte(hdr_addr ^ (8'h01 << $urandom_range(0, 7)));
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Mostly well-formed frames, short lengths, some noise
	task automatic random_phase(input int count);
		int stop;
		int pick;
		logic [7:0] len;
		stop = bytes_sent + count;
		while (bytes_sent < stop) begin
			if ($urandom_range(0, 99) < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 15)
					len = 8'd0;
				else if (pick < 75)
					len = 8'($urandom_range(1, 8));
				else
					len = 8'($urandom_range(9, 40));
				send_frame(len, $urandom_range(0, 99) < 75);
			end else begin
				send_noise($urandom_range(1, 6));
			end
		end
	endtask

	// Stop offering, wait for every result word, then let the pipe drain
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		case (idx)
			sfd_pkg::REG_FIRST_HEADER:  hdr_first  = val;
			sfd_pkg::REG_SECOND_HEADER: hdr_second = val;
			sfd_pkg::REG_NODE_ADDRESS:  hdr_addr   = val;
			default: ;
		endcase
	endtask

	task automatic set_headers(input logic [7:0] h1, input logic [7:0] h2,
	                           input logic [7:0] addr);
		set_reg(sfd_pkg::REG_FIRST_HEADER, h1);
		set_reg(sfd_pkg::REG_SECOND_HEADER, h2);
		set_reg(sfd_pkg::REG_NODE_ADDRESS, addr);
		settings_used++;
	endtask

	// Main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-made frames under the reset headers
		send_byte(hdr_first);
		send_byte(hdr_second);
		send_byte(hdr_addr ^ 8'h01);
		send_header(8'd3);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'h7F);                // good checksum
		send_header(8'd0);
		send_byte(8'h00);                // empty frame, good
		send_header(8'd0);
		send_byte(8'hFF);                // empty frame, bad
		send_header(8'd1);
		send_byte(8'hAB);
		send_byte(8'h00);                // bad checksum
		settle();

		// all-zero headers: a cleared window matches at once
		set_headers(8'h00, 8'h00, 8'h00);
		set_reg(REG_UNUSED, 8'hFF);
		random_phase(60);
		settle();

		// all-ones headers, no idling on either side
		set_headers(8'hFF, 8'hFF, 8'hFF);
		calm = 1'b1;
		random_phase(60);
		settle();
		calm = 1'b0;

		// back to defaults, with one frame of the largest length
		set_headers(sfd_pkg::RST_FIRST_HEADER, sfd_pkg::RST_SECOND_HEADER,
		            sfd_pkg::RST_NODE_ADDRESS);
		send_frame(8'd255, 1'b1);
		random_phase(40);
		settle();

		// random settings; the second one runs under a long result hold-off
		for (int i = 0; i < 3; i++) begin
			set_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			            8'($urandom_range(0, 255)));
			if (i == 1)
				hold_requests++;
			random_phase(40);
			settle();
		end

		$display("Run sent %0d bytes under %0d header settings: %0d payload words,",
		         bytes_sent, settings_used, n_payload);
		$display("%0d good and %0d bad frame ends checked", n_good, n_bad);
		if (n_pending != 0)
			$display("%0d result words never arrived", n_pending);
		if (n_fail == 0 && n_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
